### sv/keyboard_report_to_key_events_defines.svh
// Assertion macros for the keyboard report event block.
// Taken in by the checker file only; depends on nothing else.
`ifndef KEYBOARD_REPORT_TO_KEY_EVENTS_DEFINES_SVH
`define KEYBOARD_REPORT_TO_KEY_EVENTS_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define KBE_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("kbe check failed");

// Clocked check that also holds during reset.
`define KBE_ASSERT_RST(name, prop) \
	name: assert property (@(posedge clk) (prop)) \
		else $error("kbe reset check failed");

`endif

### sv/kbe_pkg.sv
// Shared types and constants for the keyboard report event block.
// Used by every module of the block; depends on nothing.
package kbe_pkg;

	localparam int REPORT_KEYS  = 6;
	localparam int MOD_BITS     = 8;
	localparam int LEN_W        = 4;
	localparam int TICK_W       = 16;
	localparam int KEY_BYTE_OFS = 2;

	localparam logic [LEN_W-1:0]  MIN_LONG_LEN    = 4'd3;
	localparam logic [LEN_W-1:0]  MAX_LEN         = 4'd8;
	localparam logic [7:0]        MOD_USAGE_BASE  = 8'hE0;
	localparam logic [TICK_W-1:0] DEFAULT_TIMEOUT = 16'd20;

	typedef logic [7:0] code_t;

	// One input item as held in the input register.
	typedef struct packed {
		logic [TICK_W-1:0]         tick;
		logic [LEN_W-1:0]          len;
		code_t                     mods;
		code_t [REPORT_KEYS-1:0]   keys;
	} item_t;

	// Report data that the event selector needs besides the held keys.
	typedef struct packed {
		code_t                     old_mods;
		code_t                     new_mods;
		code_t [REPORT_KEYS-1:0]   keys;
	} rpt_t;

endpackage

### sv/keyboard_report_to_key_events.sv
// The first event of an item goes through the input register, the event buffer and
// the output register. Throughput: one event per cycle unless the receiver stalls;
// the buffer takes the next item as its last event is sent, or whenever it is empty.
// Reset (arst_n low): held keys and modifiers and the previous tick clear, the timeout
// returns to 20, and both channels go empty.
module keyboard_report_to_key_events import kbe_pkg::*; #(
	parameter int KEY_SLOTS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] poll_tick,
	input  logic [3:0]  report_len,
	input  logic [7:0]  modifiers,
	input  logic [7:0]  key_0,
	input  logic [7:0]  key_1,
	input  logic [7:0]  key_2,
	input  logic [7:0]  key_3,
	input  logic [7:0]  key_4,
	input  logic [7:0]  key_5,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_release,
	output logic [7:0]  event_modifiers,
	output logic [7:0]  usage_code,
	output logic        last_of_run
);

	localparam int NEV = 2 * KEY_SLOTS + MOD_BITS + REPORT_KEYS;

	logic                  s1_valid;
	item_t                 item_s1;
	logic                  commit;
	logic                  load_ok;
	logic [NEV-1:0]        ev_mask;
	code_t [KEY_SLOTS-1:0] old_held;
	rpt_t                  rpt;

	assign commit   = s1_valid && load_ok;
	assign in_ready = !s1_valid || commit;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid <= 1'b1;
		end else if (commit) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{tick: poll_tick, len: report_len, mods: modifiers,
				keys: {key_5, key_4, key_3, key_2, key_1, key_0}};
		end
	end

	kbe_diff #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_diff (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.item     (item_s1),
		.commit   (commit),
		.ev_mask  (ev_mask),
		.old_held (old_held),
		.rpt      (rpt)
	);

	kbe_emit #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (commit),
		.load_mask      (ev_mask),
		.load_held      (old_held),
		.load_rpt       (rpt),
		.load_ok        (load_ok),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.is_release     (is_release),
		.event_modifiers(event_modifiers),
		.usage_code     (usage_code),
		.last_of_run    (last_of_run)
	);

endmodule

### sv/kbe_diff.sv
// Snapshot state and report comparison: builds the event mask of one item.
// Depends on kbe_pkg.
module kbe_diff import kbe_pkg::*; #(
	parameter int KEY_SLOTS = 6,
	localparam int NEV = 2 * KEY_SLOTS + MOD_BITS + REPORT_KEYS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [TICK_W-1:0]     cfg_wdata,
	input  item_t                 item,
	input  logic                  commit,
	output logic [NEV-1:0]        ev_mask,
	output code_t [KEY_SLOTS-1:0] old_held,
	output rpt_t                  rpt
);

	logic [TICK_W-1:0]     timeout_q;
	logic [TICK_W-1:0]     prev_tick_q;
	code_t                 mods_q;
	code_t [KEY_SLOTS-1:0] held_q;
	code_t [KEY_SLOTS-1:0] held_new;

	logic [TICK_W-1:0]      gap;
	logic                   tmo;
	logic [LEN_W-1:0]       len_c;
	logic                   long_rpt;
	logic [REPORT_KEYS-1:0] kv;
	logic [KEY_SLOTS-1:0]   t_mask;
	logic [KEY_SLOTS-1:0]   g_mask;
	logic [MOD_BITS-1:0]    m_mask;
	logic [REPORT_KEYS-1:0] p_mask;

	// Timeout test and the valid key bytes of the report.
	always_comb begin
		gap      = item.tick - prev_tick_q;
		tmo      = gap > timeout_q;
		len_c    = (item.len > MAX_LEN) ? MAX_LEN : item.len;
		long_rpt = len_c >= MIN_LONG_LEN;
		for (int j = 0; j < REPORT_KEYS; j++) begin
			kv[j] = long_rpt && (LEN_W'(j + KEY_BYTE_OFS) < len_c);
		end
	end

	// Timeout releases and releases of keys no longer reported.
	always_comb begin
		logic found;
		found = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			found = 1'b0;
			for (int j = 0; j < REPORT_KEYS; j++) begin
				if (kv[j] && item.keys[j] == held_q[i]) begin
					found = 1'b1;
				end
			end
			t_mask[i] = tmo && (held_q[i] != '0);
			g_mask[i] = long_rpt && !tmo && (held_q[i] != '0) && !found;
		end
	end

	// Presses of reported keys that were not held after the timeout step.
	always_comb begin
		logic found;
		found = 1'b0;
		for (int j = 0; j < REPORT_KEYS; j++) begin
			found = 1'b0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				if (!tmo && held_q[i] == item.keys[j]) begin
					found = 1'b1;
				end
			end
			p_mask[j] = kv[j] && (item.keys[j] != '0) && !found;
		end
	end

	assign m_mask   = long_rpt ? (mods_q ^ item.mods) : '0;
	assign ev_mask  = {p_mask, g_mask, m_mask, t_mask};
	assign old_held = held_q;
	assign rpt      = '{old_mods: mods_q, new_mods: item.mods, keys: item.keys};

	// New snapshot: the valid key bytes that fit, zeros elsewhere.
	for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_keep
		if (g < REPORT_KEYS) begin : g_key
			assign held_new[g] = kv[g] ? item.keys[g] : '0;
		end else begin : g_zero
			assign held_new[g] = '0;
		end
	end

	// Timeout register and snapshot state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= DEFAULT_TIMEOUT;
			prev_tick_q <= '0;
			mods_q      <= '0;
			held_q      <= '0;
		end else begin
			if (cfg_wen) begin
				timeout_q <= cfg_wdata;
			end
			if (commit) begin
				prev_tick_q <= item.tick;
				if (long_rpt) begin
					held_q <= held_new;
					mods_q <= item.mods;
				end else if (tmo) begin
					held_q <= '0;
				end
			end
		end
	end

endmodule

### sv/kbe_emit.sv
// Event buffer and output register: sends the events of one item in order.
// Depends on kbe_pkg.
module kbe_emit import kbe_pkg::*; #(
	parameter int KEY_SLOTS = 6,
	localparam int NEV = 2 * KEY_SLOTS + MOD_BITS + REPORT_KEYS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [NEV-1:0]        load_mask,
	input  code_t [KEY_SLOTS-1:0] load_held,
	input  rpt_t                  load_rpt,
	output logic                  load_ok,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  is_release,
	output code_t                 event_modifiers,
	output code_t                 usage_code,
	output logic                  last_of_run
);

	logic [NEV-1:0]        mask_s2;
	code_t [KEY_SLOTS-1:0] held_s2;
	rpt_t                  rpt_s2;

	logic                  out_valid_q;
	logic                  rel_q;
	code_t                 mods_q;
	code_t                 code_q;
	logic                  last_q;

	logic [NEV-1:0] low;
	logic [NEV-1:0] rest;
	logic           busy;
	logic           pop;
	logic           last;
	logic           sel_rel;
	code_t          sel_mods;
	code_t          sel_code;

	// Pick the lowest pending event.
	always_comb begin
		low     = mask_s2 & (~mask_s2 + NEV'(1));
		rest    = mask_s2 & ~low;
		busy    = |mask_s2;
		last    = rest == '0;
		pop     = busy && (!out_valid_q || out_ready);
		load_ok = !busy || (pop && last);
	end

	// Fields of the selected event.
	always_comb begin
		sel_rel  = 1'b0;
		sel_mods = '0;
		sel_code = '0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (low[i] || low[KEY_SLOTS + MOD_BITS + i]) begin
				sel_rel  = 1'b1;
				sel_mods = sel_mods | rpt_s2.old_mods;
				sel_code = sel_code | held_s2[i];
			end
		end
		for (int b = 0; b < MOD_BITS; b++) begin
			if (low[KEY_SLOTS + b]) begin
				sel_rel  = sel_rel | !rpt_s2.new_mods[b];
				sel_mods = sel_mods | rpt_s2.new_mods;
				sel_code = sel_code | MOD_USAGE_BASE | 8'(b);
			end
		end
		for (int j = 0; j < REPORT_KEYS; j++) begin
			if (low[2 * KEY_SLOTS + MOD_BITS + j]) begin
				sel_mods = sel_mods | rpt_s2.new_mods;
				sel_code = sel_code | rpt_s2.keys[j];
			end
		end
	end

	// Pending-event mask and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_s2 <= load_mask;
			end else if (pop) begin
				mask_s2 <= rest;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Buffered report data and output fields.
	always_ff @(posedge clk) begin
		if (load) begin
			held_s2 <= load_held;
			rpt_s2  <= load_rpt;
		end
		if (pop) begin
			rel_q  <= sel_rel;
			mods_q <= sel_mods;
			code_q <= sel_code;
			last_q <= last;
		end
	end

	assign out_valid       = out_valid_q;
	assign is_release      = rel_q;
	assign event_modifiers = mods_q;
	assign usage_code      = code_q;
	assign last_of_run     = last_q;

endmodule

### sv/kbe_checker.sv
// Port-level checks for the keyboard report event block, bound to the top level.
// Depends on keyboard_report_to_key_events_defines.svh.
`include "keyboard_report_to_key_events_defines.svh"

module kbe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       is_release,
	input logic [7:0] event_modifiers,
	input logic [7:0] usage_code,
	input logic       last_of_run
);

	// A stalled event keeps its fields.
	`KBE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(is_release) && $stable(event_modifiers) && $stable(usage_code) && $stable(last_of_run))

	// Events of one run follow each other without a gap.
	`KBE_ASSERT(a_run_cont, out_valid && out_ready && !last_of_run |=> out_valid)

	// Nothing is offered in the cycle after reset was seen low.
	`KBE_ASSERT_RST(a_rst_idle, !arst_n |=> !out_valid)

endmodule

bind keyboard_report_to_key_events kbe_checker u_kbe_checker (.*);

### test/tb_keyboard_report_to_key_events.sv
// Self-checking testbench for keyboard_report_to_key_events: a directed report table, then
// random report streams under several release timeouts. Depends on kbe_pkg and the block.
`timescale 1ns / 1ps

module tb_keyboard_report_to_key_events import kbe_pkg::*;;

	localparam int KEY_SLOTS       = 6;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int HOLD_CYCLES     = 300;
	localparam int PHASES          = 5;
	localparam int ITEMS_PER_PHASE = 28;
	localparam int STALL_ITEMS     = 24;
	localparam int SETTLE_CYCLES   = 8;
	localparam int PRED_ROW        = -1;
	localparam int MAX_PRINTS      = 100;

	typedef enum bit {PRESS = 1'b0, RELEASE = 1'b1} ev_kind_e;

	// One key event as the block emits it.
	typedef struct packed {
		ev_kind_e kind;
		code_t    mods;
		code_t    code;
		logic     run_end;
	} kbd_event_t;

	// One report plus, for table rows, the events typed in by hand.
	typedef struct packed {
		item_t      it;
		int         n_typed;
		kbd_event_t ev0;
		kbd_event_t ev1;
	} report_row_t;

	localparam kbd_event_t NO_EV = '0;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        is_release;
	logic [7:0]  event_modifiers;
	logic [7:0]  usage_code;
	logic        last_of_run;

	report_row_t offer_row = '0;

	// Predictor state: held key snapshot, held modifiers, last tick and timeout.
	code_t       snap_keys [KEY_SLOTS];
	code_t       snap_mods     = '0;
	logic [15:0] pred_tick     = '0;
	logic [15:0] release_after = DEFAULT_TIMEOUT;

	kbd_event_t  pending_events [$];
	kbd_event_t  report_events [$];
	int          err_count   = 0;
	int          cycle_count = 0;
	bit          no_idle     = 1'b0;
	bit          hold_req    = 1'b0;

	// Random stimulus state, kept apart from the predictor.
	logic [15:0]                   stim_tick    = '0;
	logic [15:0]                   stim_timeout = DEFAULT_TIMEOUT;
	code_t                         stim_mods    = '0;
	code_t [REPORT_KEYS-1:0]       stim_keys    = '0;

	keyboard_report_to_key_events #(
		.KEY_SLOTS(KEY_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.poll_tick(offer_row.it.tick),
		.report_len(offer_row.it.len),
		.modifiers(offer_row.it.mods),
		.key_0(offer_row.it.keys[0]),
		.key_1(offer_row.it.keys[1]),
		.key_2(offer_row.it.keys[2]),
		.key_3(offer_row.it.keys[3]),
		.key_4(offer_row.it.keys[4]),
		.key_5(offer_row.it.keys[5]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_release(is_release),
		.event_modifiers(event_modifiers),
		.usage_code(usage_code),
		.last_of_run(last_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic kbd_event_t ev(input ev_kind_e k, input int m, input int c, input bit e);
		kbd_event_t r;
		r.kind    = k;
		r.mods    = code_t'(m);
		r.code    = code_t'(c);
		r.run_end = e;
		return r;
	endfunction

	function automatic report_row_t row(input int t, input int l, input int m, input int k0,
			input int k1, input int k2, input int k3, input int k4, input int k5,
			input int n, input kbd_event_t e0, input kbd_event_t e1);
		report_row_t r;
		r.it.tick    = 16'(t);
		r.it.len     = 4'(l);
		r.it.mods    = code_t'(m);
		r.it.keys[0] = code_t'(k0);
		r.it.keys[1] = code_t'(k1);
		r.it.keys[2] = code_t'(k2);
		r.it.keys[3] = code_t'(k3);
		r.it.keys[4] = code_t'(k4);
		r.it.keys[5] = code_t'(k5);
		r.n_typed    = n;
		r.ev0        = e0;
		r.ev1        = e1;
		return r;
	endfunction

	// Computes the events of one report and advances the snapshot state.
	task automatic derive_events(input item_t it, ref kbd_event_t evs[$]);
		logic [15:0] gap;
		int          len_c;
		int          nk;
		code_t       old_m;
		bit          found;
		int          i;
		int          j;
		int          b;
		gap = it.tick - pred_tick;
		if (gap > release_after) begin
			for (i = 0; i < KEY_SLOTS; i++)
				if (snap_keys[i] != 0)
					evs.push_back(ev(RELEASE, snap_mods, snap_keys[i], 1'b0));
			for (i = 0; i < KEY_SLOTS; i++)
				snap_keys[i] = '0;
		end
		pred_tick = it.tick;
		len_c = (it.len > MAX_LEN) ? int'(MAX_LEN) : int'(it.len);
		if (len_c >= int'(MIN_LONG_LEN)) begin
			nk    = len_c - KEY_BYTE_OFS;
			old_m = snap_mods;
			// Modifier bit changes, bit 0 first, with the new modifier byte.
			for (b = 0; b < 8; b++)
				if (old_m[b] != it.mods[b])
					evs.push_back(ev(it.mods[b] ? PRESS : RELEASE, it.mods,
						MOD_USAGE_BASE + b, 1'b0));
			// Held keys that are no longer reported carry the old modifiers.
			for (i = 0; i < KEY_SLOTS; i++) begin
				if (snap_keys[i] == 0)
					continue;
				found = 1'b0;
				for (j = 0; j < nk; j++)
					if (it.keys[j] == snap_keys[i])
						found = 1'b1;
				if (!found)
					evs.push_back(ev(RELEASE, old_m, snap_keys[i], 1'b0));
			end
			// Newly reported keys; a repeated new code presses twice.
			for (j = 0; j < nk; j++) begin
				if (it.keys[j] == 0)
					continue;
				found = 1'b0;
				for (i = 0; i < KEY_SLOTS; i++)
					if (snap_keys[i] == it.keys[j])
						found = 1'b1;
				if (!found)
					evs.push_back(ev(PRESS, it.mods, it.keys[j], 1'b0));
			end
			for (i = 0; i < KEY_SLOTS; i++)
				snap_keys[i] = (i < nk) ? it.keys[i] : '0;
			snap_mods = it.mods;
		end
		if (evs.size() > 0)
			evs[evs.size() - 1].run_end = 1'b1;
	endtask

	// Timeout writes and accepted reports update the expectations.
	always @(posedge clk) begin
		if (arst_n && cfg_wen)
			release_after = cfg_wdata;
		if (arst_n && in_valid && in_ready) begin
			report_events.delete();
			derive_events(offer_row.it, report_events);
			if (offer_row.n_typed == PRED_ROW) begin
				foreach (report_events[k])
					pending_events.push_back(report_events[k]);
			end else begin
				if (offer_row.n_typed > 0)
					pending_events.push_back(offer_row.ev0);
				if (offer_row.n_typed > 1)
					pending_events.push_back(offer_row.ev1);
			end
		end
	end

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			if (err_count < MAX_PRINTS)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
			err_count++;
		end
	endtask

	// Each accepted event is compared with the oldest expectation.
	always @(posedge clk) begin
		kbd_event_t exp_ev;
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				if (err_count < MAX_PRINTS)
					$display("%0t: unexpected event, expected none, got %0h %0h %0h %0h", $time,
						is_release, event_modifiers, usage_code, last_of_run);
				err_count++;
			end else begin
				exp_ev = pending_events.pop_front();
				check_field("is_release", exp_ev.kind, is_release);
				check_field("event_modifiers", exp_ev.mods, event_modifiers);
				check_field("usage_code", exp_ev.code, usage_code);
				check_field("last_of_run", exp_ev.run_end, last_of_run);
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_keyboard_report_to_key_events: errors");
			$finish;
		end
	end

	function automatic int idle_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int pick_gap();
		if (no_idle || $urandom_range(0, 1) == 0)
			return 0;
		return idle_len();
	endfunction

	// Receiver: random stalls, one long hold-off on request, none in full-speed phases.
	initial begin : receiver
		int rx_wait;
		int k;
		rx_wait = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
				hold_req = 1'b0;
			end else if (no_idle || rx_wait == 0) begin
				out_ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 3) == 0)
					rx_wait = idle_len();
			end else begin
				out_ready <= 1'b0;
				rx_wait--;
			end
		end
	end

	function automatic code_t pool_key();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return '0;
		if (r < 9)
			return code_t'(8'h04 + $urandom_range(0, 7));
		return code_t'($urandom_range(0, 255));
	endfunction

	// Mostly well-formed report streams over a small key pool, some short and some noise.
	function automatic report_row_t next_report();
		report_row_t r;
		int          sel;
		int          step;
		int          i;
		int          mb;
		r         = '0;
		r.n_typed = PRED_ROW;
		sel       = $urandom_range(0, 19);
		if (sel == 0) begin
			r.it.tick = 16'($urandom);
			r.it.len  = 4'($urandom);
			r.it.mods = code_t'($urandom);
			r.it.keys = 48'({$urandom, $urandom});
			stim_tick = r.it.tick;
			return r;
		end
		step = $urandom_range(0, 9);
		if (step == 0)
			stim_tick = 16'(stim_tick + stim_timeout + $urandom_range(0, 1));
		else if (step == 1)
			stim_tick = 16'(stim_tick + $urandom_range(0, 65535));
		else
			stim_tick = 16'(stim_tick + $urandom_range(0, 4));
		r.it.tick = stim_tick;
		if (sel == 1) begin
			r.it.len  = 4'($urandom_range(0, 2));
			r.it.mods = code_t'($urandom);
			r.it.keys = 48'({$urandom, $urandom});
			return r;
		end
		sel = $urandom_range(0, 9);
		if (sel < 7)
			r.it.len = MAX_LEN;
		else if (sel < 9)
			r.it.len = 4'($urandom_range(3, 7));
		else
			r.it.len = 4'($urandom_range(9, 15));
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			stim_mods = code_t'($urandom);
		end else if (sel < 4) begin
			mb            = $urandom_range(0, 7);
			stim_mods[mb] = ~stim_mods[mb];
		end
		r.it.mods = stim_mods;
		for (i = 0; i < REPORT_KEYS; i++)
			r.it.keys[i] = ($urandom_range(0, 2) == 0) ? pool_key() : stim_keys[i];
		if ($urandom_range(0, 15) == 0)
			r.it.keys[1] = r.it.keys[0];
		if ($urandom_range(0, 7) == 0)
			r.it.keys = {r.it.keys[4:0], r.it.keys[5]};
		stim_keys = r.it.keys;
		return r;
	endfunction

	task automatic send_report(input report_row_t r);
		offer_row <= r;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic sender_gap(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every expected event has come out.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] v);
		cfg_wdata <= v;
		cfg_wen   <= 1'b1;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	initial begin : stimulus
		report_row_t dir_tab [22];
		logic [15:0] tmo;
		int          p;
		int          i;
		for (i = 0; i < KEY_SLOTS; i++)
			snap_keys[i] = '0;

		// Directed reports under the reset timeout of 20; hand-typed rows have n >= 0.
		dir_tab = '{
			row(1, 8, 'h00, 'h04, 0, 0, 0, 0, 0, 1, ev(PRESS, 'h00, 'h04, 1), NO_EV),
			row(2, 8, 'h00, 'h04, 'h05, 0, 0, 0, 0, 1, ev(PRESS, 'h00, 'h05, 1), NO_EV),
			row(3, 2, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 0, NO_EV, NO_EV),
			row(4, 0, 'h00, 0, 0, 0, 0, 0, 0, 0, NO_EV, NO_EV),
			row(5, 8, 'h01, 'h04, 'h05, 0, 0, 0, 0, 1, ev(PRESS, 'h01, 'hE0, 1), NO_EV),
			row(6, 8, 'h00, 'h05, 'h04, 0, 0, 0, 0, 1, ev(RELEASE, 'h00, 'hE0, 1), NO_EV),
			row(7, 8, 'h00, 'h05, 0, 0, 0, 0, 0, 1, ev(RELEASE, 'h00, 'h04, 1), NO_EV),
			row(28, 8, 'h00, 'h05, 0, 0, 0, 0, 0, 2,
				ev(RELEASE, 'h00, 'h05, 0), ev(PRESS, 'h00, 'h05, 1)),
			row(48, 8, 'h00, 'h05, 0, 0, 0, 0, 0, 0, NO_EV, NO_EV),
			row(100, 1, 'h00, 'h33, 0, 0, 0, 0, 0, 1, ev(RELEASE, 'h00, 'h05, 1), NO_EV),
			row(101, 15, 'hFF, 'hFF, 'hFE, 'hFD, 'hFC, 'hFB, 'hFA, PRED_ROW, NO_EV, NO_EV),
			row(102, 8, 'h00, 0, 0, 0, 0, 0, 0, PRED_ROW, NO_EV, NO_EV),
			row(103, 8, 'h00, 1, 2, 3, 4, 5, 6, PRED_ROW, NO_EV, NO_EV),
			row(200, 8, 'hFF, 7, 8, 9, 'h0A, 'h0B, 'h0C, PRED_ROW, NO_EV, NO_EV),
			row(201, 8, 'hFF, 'h0D, 'h0D, 'h07, 0, 0, 0, PRED_ROW, NO_EV, NO_EV),
			row(202, 4, 'hFF, 'h0D, 'h07, 'h0E, 'h0F, 'h10, 'h11, 0, NO_EV, NO_EV),
			row(203, 3, 'hFF, 'h07, 'h0D, 0, 0, 0, 0, 1, ev(RELEASE, 'hFF, 'h0D, 1), NO_EV),
			row(65530, 8, 'hFF, 'h07, 0, 0, 0, 0, 0, 2,
				ev(RELEASE, 'hFF, 'h07, 0), ev(PRESS, 'hFF, 'h07, 1)),
			row(4, 8, 'hFF, 'h07, 0, 0, 0, 0, 0, 0, NO_EV, NO_EV),
			row(5, 8, 'h5A, 'h07, 'h80, 0, 0, 0, 0, PRED_ROW, NO_EV, NO_EV),
			row(6, 9, 'hA5, 0, 0, 'h07, 0, 0, 'h80, PRED_ROW, NO_EV, NO_EV),
			row(65535, 8, 'hA5, 0, 0, 'h07, 0, 0, 'h80, PRED_ROW, NO_EV, NO_EV)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[k]) begin
			send_report(dir_tab[k]);
			sender_gap(pick_gap());
		end
		settle();
		stim_tick = pred_tick;

		// Random phases: full speed, zero timeout with a long receiver hold-off, then others.
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: tmo = 16'hFFFF;
				1: tmo = 16'h0000;
				2: tmo = 16'($urandom_range(1, 60));
				3: tmo = DEFAULT_TIMEOUT;
				default: tmo = 16'd3;
			endcase
			no_idle      = (p == 0);
			stim_timeout = tmo;
			write_timeout(tmo);
			if (p == 1)
				hold_req = 1'b1;
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				send_report(next_report());
				if (!(p == 1 && i < STALL_ITEMS))
					sender_gap(pick_gap());
			end
			settle();
		end

		if (err_count == 0)
			$display("tb_keyboard_report_to_key_events: clean");
		else
			$display("tb_keyboard_report_to_key_events: errors");
		$finish;
	end

endmodule
